>>> hw/rtl/rsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsm_pkg: shared types and constants of the residual SNR meter
// Beat formats, the queue entry between front and back, register indexes and
// the fixed constants of the SNR computation.
// ----------------------------------------------------------------------------
package rsm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int RES_W     = SAMPLE_W + 1;
    localparam int SNR_W     = 32;
    localparam int EN_W      = 44;
    localparam int RES_EN_W  = 46;
    localparam int FLOOR_W   = 44;
    localparam int FRAC_W    = 16;
    localparam int LOG_INT_W = 6;
    localparam int LOG_W     = LOG_INT_W + FRAC_W;
    localparam int DIV_W     = EN_W + FRAC_W;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = LOG_W + 32;

    localparam logic [31:0]      TEN_LOG10_2_Q30 = 32'd3232284966;
    localparam logic [SNR_W-1:0] DB_DEFAULT_Q16  = 32'hFFB0_0000;
    localparam logic [SNR_W-1:0] SNR_MAX_Q16     = 32'h7FFF_FFFF;
    localparam logic [FLOOR_W-1:0] SYN_FLOOR_RST = 44'd1073742;
    localparam logic [FLOOR_W-1:0] ORG_FLOOR_RST = 44'd10737418;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SNR_IN_DB = 2'd0,
        CFG_SYN_FLOOR = 2'd1,
        CFG_ORG_FLOOR = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] synth_sample;
        logic signed [SAMPLE_W-1:0] original_sample;
        logic                       frame_end;
    } t_in_beat;

    typedef struct packed {
        logic signed [RES_W-1:0] residual_sample;
        logic                    snr_valid;
        logic signed [SNR_W-1:0] snr_value;
    } t_out_beat;

    typedef struct packed {
        logic signed [RES_W-1:0] residual;
        logic                    frame_end;
        logic [EN_W-1:0]         syn_sum;
        logic [EN_W-1:0]         org_sum;
        logic [RES_EN_W-1:0]     res_sum;
    } t_entry;

    typedef struct packed {
        logic snr_in_db;
        logic [FLOOR_W-1:0] syn_floor;
        logic [FLOOR_W-1:0] org_floor;
    } t_cfg;

endpackage
`default_nettype wire

>>> hw/rtl/rsm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsm_front: sample front end
// Forms the residual, squares the three samples and keeps the saturating
// frame energy sums; every beat leaves as one queue entry.
// ----------------------------------------------------------------------------
module rsm_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_stall,
    input  rsm_pkg::t_in_beat i_data,
    input  wire              i_full,
    output logic             o_push,
    output rsm_pkg::t_entry  o_entry
);
    import rsm_pkg::*;

    logic                       r_s1_vld;
    logic signed [SAMPLE_W-1:0] r_syn, r_org;
    logic                       r_end1;
    logic                       r_s2_vld;
    logic [31:0]                r_sq_s, r_sq_o;
    logic [32:0]                r_sq_d;
    logic signed [RES_W-1:0]    r_res;
    logic                       r_end2;
    logic [EN_W-1:0]            r_syn_sum, n_syn_sum;
    logic [EN_W-1:0]            r_org_sum, n_org_sum;
    logic [RES_EN_W-1:0]        r_res_sum, n_res_sum;

    logic                       adv;
    logic signed [RES_W-1:0]    diff;
    logic signed [2*RES_W-1:0]  sq_d;
    logic [EN_W:0]              add_s, add_o;
    logic [RES_EN_W:0]          add_d;

    assign adv     = !(r_s2_vld && i_full);
    assign o_stall = !adv;
    assign o_push  = r_s2_vld && adv;
    assign diff    = RES_W'(r_syn) - RES_W'(r_org);
    assign sq_d    = diff * diff;

    always_comb begin
        add_s = {1'b0, r_syn_sum} + (EN_W + 1)'(r_sq_s);
        add_o = {1'b0, r_org_sum} + (EN_W + 1)'(r_sq_o);
        add_d = {1'b0, r_res_sum} + (RES_EN_W + 1)'(r_sq_d);
        n_syn_sum = add_s[EN_W] ? {EN_W{1'b1}} : add_s[EN_W-1:0];
        n_org_sum = add_o[EN_W] ? {EN_W{1'b1}} : add_o[EN_W-1:0];
        n_res_sum = add_d[RES_EN_W] ? {RES_EN_W{1'b1}} : add_d[RES_EN_W-1:0];
        o_entry.residual  = r_res;
        o_entry.frame_end = r_end2;
        o_entry.syn_sum   = n_syn_sum;
        o_entry.org_sum   = n_org_sum;
        o_entry.res_sum   = n_res_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_syn_sum <= '0;
            r_org_sum <= '0;
            r_res_sum <= '0;
        end else begin
            if (adv) begin
                r_s1_vld <= i_valid;
                r_s2_vld <= r_s1_vld;
            end
            if (o_push) begin
                r_syn_sum <= r_end2 ? '0 : n_syn_sum;
                r_org_sum <= r_end2 ? '0 : n_org_sum;
                r_res_sum <= r_end2 ? '0 : n_res_sum;
            end
        end
        if (adv) begin
            r_syn  <= i_data.synth_sample;
            r_org  <= i_data.original_sample;
            r_end1 <= i_data.frame_end;
            r_sq_s <= 32'(r_syn * r_syn);
            r_sq_o <= 32'(r_org * r_org);
            r_sq_d <= sq_d[32:0];
            r_res  <= diff;
            r_end2 <= r_end1;
        end
    end

`ifndef NO_ASSERTIONS
    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_end2) |=> (r_syn_sum == '0 && r_res_sum == '0))
        else $error("frame sums not cleared after frame end");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/rsm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsm_queue: two-entry queue between front and back
// Lets the front keep accumulating while the back works on a frame end.
// ----------------------------------------------------------------------------
module rsm_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  rsm_pkg::t_entry i_entry,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_empty,
    output rsm_pkg::t_entry o_entry
);
    import rsm_pkg::*;

    t_entry     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_entry;
    end

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("queue overrun or underrun");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/rsm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsm_back: SNR sequencer and output register
// Takes one queue entry at a time; a frame end above both floors with residual
// energy runs a bit-serial divider or two log2 passes and a scaling multiply.
// ----------------------------------------------------------------------------
module rsm_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  rsm_pkg::t_cfg     i_cfg,
    input  wire               i_empty,
    input  rsm_pkg::t_entry   i_entry,
    output logic              o_pop,
    output logic              o_valid,
    input  wire               i_stall,
    output rsm_pkg::t_out_beat o_data
);
    import rsm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_NORM = 7'b0000100,
        S_SQR  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_RND  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    t_entry              r_entry, n_entry;
    logic [SNR_W-1:0]    r_snr, n_snr;
    logic [RES_EN_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0]    r_dvd, n_dvd;
    logic [31:0]         r_q, n_q;
    logic                r_ovf, n_ovf;
    logic [5:0]          r_cnt, n_cnt;
    logic [RES_EN_W-1:0] r_x, n_x;
    logic [LOG_INT_W-1:0] r_n, n_n;
    logic [31:0]         r_m, n_m;
    logic [FRAC_W-1:0]   r_frac, n_frac;
    logic                r_pass, n_pass;
    logic [LOG_W-1:0]    r_ln, n_ln;
    logic [LOG_W-1:0]    r_ld, n_ld;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic                r_neg, n_neg;
    logic                r_out_vld, n_out_vld;
    t_out_beat           r_out, n_out;

    logic [RES_EN_W:0]   rem2;
    logic                ge;
    logic [63:0]         sq;
    logic [LOG_W:0]      ldiff;
    logic [LOG_W-1:0]    absd;
    logic [PROD_W:0]     rsum;
    logic [SNR_W-1:0]    mag;

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    always_comb begin
        n_state = r_state;   n_entry = r_entry; n_snr = r_snr;
        n_rem = r_rem;       n_dvd = r_dvd;     n_q = r_q;
        n_ovf = r_ovf;       n_cnt = r_cnt;     n_x = r_x;
        n_n = r_n;           n_m = r_m;         n_frac = r_frac;
        n_pass = r_pass;     n_ln = r_ln;       n_ld = r_ld;
        n_prod = r_prod;     n_neg = r_neg;
        n_out_vld = r_out_vld && i_stall;
        n_out = r_out;
        rem2  = {r_rem, r_dvd[DIV_W-1]};
        ge    = rem2 >= {1'b0, r_entry.res_sum};
        sq    = 64'(r_m) * 64'(r_m);
        ldiff = {1'b0, r_ln} - {1'b0, r_ld};
        absd  = ldiff[LOG_W] ? LOG_W'(-ldiff) : ldiff[LOG_W-1:0];
        rsum  = {1'b0, r_prod} + (PROD_W + 1)'(1 << 29);
        mag   = SNR_W'(rsum[PROD_W:30]);
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_entry = i_entry;
                    n_state = S_DONE;
                    if (!i_entry.frame_end) begin
                        n_snr = '0;
                    end else if (!(i_entry.syn_sum > i_cfg.syn_floor &&
                                   i_entry.org_sum > i_cfg.org_floor)) begin
                        n_snr = i_cfg.snr_in_db ? DB_DEFAULT_Q16 : '0;
                    end else if (i_entry.res_sum == '0) begin
                        n_snr = SNR_MAX_Q16;
                    end else if (i_cfg.snr_in_db) begin
                        n_x     = RES_EN_W'(i_entry.org_sum);
                        n_n     = LOG_INT_W'(RES_EN_W - 1);
                        n_pass  = 1'b0;
                        n_state = S_NORM;
                    end else begin
                        n_rem   = '0;
                        n_dvd   = {i_entry.org_sum, FRAC_W'(0)};
                        n_q     = '0;
                        n_ovf   = 1'b0;
                        n_cnt   = 6'(DIV_W);
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem = ge ? RES_EN_W'(rem2 - {1'b0, r_entry.res_sum}) : rem2[RES_EN_W-1:0];
                n_dvd = r_dvd << 1;
                n_q   = {r_q[30:0], ge};
                n_ovf = r_ovf | r_q[31];
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    n_snr   = (n_ovf || n_q[31]) ? SNR_MAX_Q16 : n_q;
                    n_state = S_DONE;
                end
            end
            S_NORM: begin
                if (r_x[RES_EN_W-1]) begin
                    n_m     = r_x[RES_EN_W-1 -: 32];
                    n_frac  = '0;
                    n_cnt   = 6'(FRAC_W);
                    n_state = S_SQR;
                end else begin
                    n_x = r_x << 1;
                    n_n = r_n - LOG_INT_W'(1);
                end
            end
            S_SQR: begin
                n_m    = sq[63] ? sq[63:32] : sq[62:31];
                n_frac = {r_frac[FRAC_W-2:0], sq[63]};
                n_cnt  = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    if (!r_pass) begin
                        n_ln    = {r_n, n_frac};
                        n_x     = r_entry.res_sum;
                        n_n     = LOG_INT_W'(RES_EN_W - 1);
                        n_pass  = 1'b1;
                        n_state = S_NORM;
                    end else begin
                        n_ld    = {r_n, n_frac};
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(absd) * PROD_W'(TEN_LOG10_2_Q30);
                n_neg   = ldiff[LOG_W];
                n_state = S_RND;
            end
            S_RND: begin
                n_snr   = r_neg ? -mag : mag;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || !i_stall) begin
                    n_out_vld             = 1'b1;
                    n_out.residual_sample = r_entry.residual;
                    n_out.snr_valid       = r_entry.frame_end;
                    n_out.snr_value       = r_snr;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
        r_entry <= n_entry; r_snr <= n_snr;   r_rem <= n_rem;
        r_dvd <= n_dvd;     r_q <= n_q;       r_ovf <= n_ovf;
        r_cnt <= n_cnt;     r_x <= n_x;       r_n <= n_n;
        r_m <= n_m;         r_frac <= n_frac; r_pass <= n_pass;
        r_ln <= n_ln;       r_ld <= n_ld;     r_prod <= n_prod;
        r_neg <= n_neg;     r_out <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_plain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.snr_valid) |-> (r_out.snr_value == '0))
        else $error("SNR value set on a beat that closes no frame");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/residual_snr_meter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// residual_snr_meter_top: residual and per-frame SNR meter
// Emits synth minus original for every sample pair and, on the last pair of
// a frame, the frame SNR in Q16.16, in dB or as a linear energy ratio.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Beat
//  in        input      i_in_valid / o_in_stall   t_in_beat
//  out       output     o_out_valid / i_out_stall t_out_beat
//  cfg       input      i_cfg_valid / o_cfg_ready index, data
//
// A beat that does not close a frame passes through two front stages, the
// queue and the back sequencer. A frame end in linear mode adds the
// one-bit-per-cycle divider; in dB mode it adds two log2 passes, each a
// normalizing shift loop plus 16 squarings on one 32x32 multiplier, and a
// scaling multiply and a rounding step. Reset is synchronous and active low;
// it clears the frame sums and loads the register defaults. A stall at the
// output backs up through the queue to o_in_stall.
// ----------------------------------------------------------------------------
module residual_snr_meter_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  rsm_pkg::t_in_beat            i_in_data,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output rsm_pkg::t_out_beat           o_out_data,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [rsm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [rsm_pkg::FLOOR_W-1:0]   i_cfg_data
);
    import rsm_pkg::*;

    // Configuration registers. Writes are always taken; an unused index
    // is dropped.
    t_cfg   r_cfg;
    logic   push, pop, full, empty;
    t_entry push_entry, pop_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.snr_in_db <= 1'b1;
            r_cfg.syn_floor <= SYN_FLOOR_RST;
            r_cfg.org_floor <= ORG_FLOOR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SNR_IN_DB: r_cfg.snr_in_db <= i_cfg_data[0];
                CFG_SYN_FLOOR: r_cfg.syn_floor <= i_cfg_data;
                CFG_ORG_FLOOR: r_cfg.org_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front squares and accumulates every beat; the queue lets it run
    // ahead while the back grinds through a frame-end computation.
    rsm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    rsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_entry (pop_entry)
    );

    rsm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_entry (pop_entry),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule
`default_nettype wire
